// ----- rtl/mms_pkg.sv -----
// Shared constants for the motion magnitude smoother.
`default_nettype none

package mms_pkg;

    localparam int SAMPLE_BITS_DEF = 16;
    localparam int DRIVE_SHIFT_DEF = 5;

    localparam int MAG_W    = 16;
    localparam int WEIGHT_W = 9;
    localparam int BASE_W   = 8;
    localparam int DRIVE_W  = 8;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;

    localparam logic [CFG_INDEX_W-1:0] REG_NEW_WEIGHT    = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_LEVEL_CEILING = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_BASE_DRIVE    = 2'd2;

    localparam logic [WEIGHT_W-1:0] WEIGHT_FULL = 9'd256;

    localparam logic [WEIGHT_W-1:0] NEW_WEIGHT_RST    = 9'd56;
    localparam logic [MAG_W-1:0]    LEVEL_CEILING_RST = 16'd4800;
    localparam logic [BASE_W-1:0]   BASE_DRIVE_RST    = 8'd50;

endpackage

`default_nettype wire

// ----- rtl/mms_root.sv -----
// Bit-serial sum of squares followed by a bit-by-bit floor square root.
`default_nettype none

module mms_root #(
    parameter int SAMPLE_BITS = mms_pkg::SAMPLE_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic signed [SAMPLE_BITS-1:0] accel_x,
    input  logic signed [SAMPLE_BITS-1:0] accel_y,
    output logic                          done,
    output logic [mms_pkg::MAG_W-1:0]     magnitude
);

    localparam int SQ_W  = 2 * SAMPLE_BITS;
    localparam int REM_W = SAMPLE_BITS + 3;
    localparam int CNT_W = $clog2(SAMPLE_BITS);
    localparam int RW    = (SAMPLE_BITS > mms_pkg::MAG_W) ? SAMPLE_BITS : mms_pkg::MAG_W;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SQUARE,
        ST_ROOT
    } state_t;

    state_t                 state_reg;
    logic [CNT_W-1:0]       cnt_reg;
    logic [SAMPLE_BITS-1:0] mx_reg;
    logic [SAMPLE_BITS-1:0] my_reg;
    logic [SQ_W-1:0]        ex_reg;
    logic [SQ_W-1:0]        ey_reg;
    logic [SQ_W-1:0]        sum_reg;
    logic [REM_W-1:0]       rem_reg;
    logic [SAMPLE_BITS-1:0] root_reg;
    logic                   done_reg;

    logic [SAMPLE_BITS-1:0] x_u;
    logic [SAMPLE_BITS-1:0] y_u;
    logic [SAMPLE_BITS-1:0] ax;
    logic [SAMPLE_BITS-1:0] ay;
    logic [SQ_W-1:0]        sum_next;
    logic [REM_W-1:0]       rem_sh;
    logic [REM_W-1:0]       trial;
    logic                   last_step;
    logic [RW-1:0]          root_ext;

    assign x_u = accel_x;
    assign y_u = accel_y;
    // -2^(N-1) maps to 2^(N-1), which still fits unsigned
    assign ax  = x_u[SAMPLE_BITS-1] ? SAMPLE_BITS'(~x_u + 1'b1) : x_u;
    assign ay  = y_u[SAMPLE_BITS-1] ? SAMPLE_BITS'(~y_u + 1'b1) : y_u;

    assign sum_next = sum_reg + (mx_reg[0] ? ex_reg : '0) + (my_reg[0] ? ey_reg : '0);

    assign rem_sh = {rem_reg[REM_W-3:0], sum_reg[SQ_W-1 -: 2]};
    assign trial  = {1'b0, root_reg, 2'b01};

    assign last_step = (cnt_reg == CNT_W'(SAMPLE_BITS - 1));

    assign root_ext  = RW'(root_reg);
    assign magnitude = (root_ext > RW'({mms_pkg::MAG_W{1'b1}})) ? {mms_pkg::MAG_W{1'b1}}
                                                                : root_ext[mms_pkg::MAG_W-1:0];
    assign done = done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (start)
                    begin
                        mx_reg    <= ax;
                        my_reg    <= ay;
                        ex_reg    <= SQ_W'(ax);
                        ey_reg    <= SQ_W'(ay);
                        sum_reg   <= '0;
                        cnt_reg   <= '0;
                        state_reg <= ST_SQUARE;
                    end
                end
                ST_SQUARE:
                begin
                    sum_reg <= sum_next;
                    mx_reg  <= mx_reg >> 1;
                    my_reg  <= my_reg >> 1;
                    ex_reg  <= ex_reg << 1;
                    ey_reg  <= ey_reg << 1;
                    cnt_reg <= cnt_reg + 1'b1;
                    if (last_step)
                    begin
                        cnt_reg   <= '0;
                        rem_reg   <= '0;
                        root_reg  <= '0;
                        state_reg <= ST_ROOT;
                    end
                end
                ST_ROOT:
                begin
                    sum_reg <= sum_reg << 2;
                    cnt_reg <= cnt_reg + 1'b1;
                    if (rem_sh >= trial)
                    begin
                        rem_reg  <= rem_sh - trial;
                        root_reg <= {root_reg[SAMPLE_BITS-2:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg  <= rem_sh;
                        root_reg <= {root_reg[SAMPLE_BITS-2:0], 1'b0};
                    end
                    if (last_step)
                    begin
                        done_reg  <= 1'b1;
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// ----- rtl/motion_magnitude_smoother.sv -----
// Top level: config registers, control, bit-serial blend, clamp and drive output.
`default_nettype none

// Each request carries one signed X/Y sample pair and yields one result holding the
// floor root of x*x+y*y, the updated smoothed level and the drive level. One request
// is in work at a time and passes in order through the bit-serial squarer, the root
// unit (one root bit per cycle), bit-serial weighting over the 9 weight bits, and a
// final clamp/drive step that waits until the output register can take the result.
// A new request is taken as soon as the previous one leaves the datapath, even while
// its result still sits in the output register. Config writes are always ready and
// belong in idle periods only; writes to an unknown index are dropped.
module motion_magnitude_smoother #(
    parameter int SAMPLE_BITS = mms_pkg::SAMPLE_BITS_DEF,
    parameter int DRIVE_SHIFT = mms_pkg::DRIVE_SHIFT_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic signed [SAMPLE_BITS-1:0]       accel_x,
    input  logic signed [SAMPLE_BITS-1:0]       accel_y,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [mms_pkg::MAG_W-1:0]           magnitude,
    output logic [mms_pkg::MAG_W-1:0]           smoothed,
    output logic [mms_pkg::DRIVE_W-1:0]         drive,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [mms_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [mms_pkg::CFG_DATA_W-1:0]      cfg_data
);

    localparam int MAG_W  = mms_pkg::MAG_W;
    localparam int W_W    = mms_pkg::WEIGHT_W;
    localparam int PROD_W = MAG_W + W_W - 1;
    localparam int BCNT_W = $clog2(W_W);
    localparam int DSUM_W = MAG_W + 1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ROOT,
        ST_BLEND,
        ST_FINISH
    } state_t;

    state_t                        state_reg;
    logic [BCNT_W-1:0]             bcnt_reg;
    logic [W_W-1:0]                wsh_reg;
    logic [W_W-1:0]                wcsh_reg;
    logic [PROD_W-1:0]             root_sh_reg;
    logic [PROD_W-1:0]             lvl_sh_reg;
    logic [PROD_W-1:0]             acc_reg;
    logic [MAG_W-1:0]              mag_reg;
    logic [MAG_W-1:0]              level_reg;
    logic                          out_valid_reg;
    logic [MAG_W-1:0]              magnitude_reg;
    logic [MAG_W-1:0]              smoothed_reg;
    logic [mms_pkg::DRIVE_W-1:0]   drive_reg;

    logic [W_W-1:0]                new_weight_reg;
    logic [MAG_W-1:0]              level_ceiling_reg;
    logic [mms_pkg::BASE_W-1:0]    base_drive_reg;

    logic                          root_done;
    logic [MAG_W-1:0]              root_mag;
    logic [W_W-1:0]                w_eff;
    logic [W_W-1:0]                w_old;
    logic [PROD_W-1:0]             acc_next;
    logic [MAG_W-1:0]              lvl_raw;
    logic [MAG_W-1:0]              level_next;
    logic [DSUM_W-1:0]             drive_sum;
    logic [mms_pkg::DRIVE_W-1:0]   drive_next;
    logic                          load_out;

    mms_root #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_root (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (in_valid && in_ready),
        .accel_x   (accel_x),
        .accel_y   (accel_y),
        .done      (root_done),
        .magnitude (root_mag)
    );

    assign in_ready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign magnitude = magnitude_reg;
    assign smoothed  = smoothed_reg;
    assign drive     = drive_reg;

    assign w_eff = (new_weight_reg > mms_pkg::WEIGHT_FULL) ? mms_pkg::WEIGHT_FULL
                                                           : new_weight_reg;
    assign w_old = mms_pkg::WEIGHT_FULL - w_eff;

    assign acc_next = acc_reg + (wsh_reg[0] ? root_sh_reg : '0)
                              + (wcsh_reg[0] ? lvl_sh_reg : '0);

    assign lvl_raw    = acc_reg[PROD_W-1 -: MAG_W];
    assign level_next = (lvl_raw > level_ceiling_reg) ? level_ceiling_reg : lvl_raw;
    assign drive_sum  = DSUM_W'(base_drive_reg) + DSUM_W'(level_next >> DRIVE_SHIFT);
    assign drive_next = (drive_sum > DSUM_W'({mms_pkg::DRIVE_W{1'b1}}))
                      ? {mms_pkg::DRIVE_W{1'b1}} : drive_sum[mms_pkg::DRIVE_W-1:0];

    assign load_out = (state_reg == ST_FINISH) && (!out_valid_reg || out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            new_weight_reg    <= mms_pkg::NEW_WEIGHT_RST;
            level_ceiling_reg <= mms_pkg::LEVEL_CEILING_RST;
            base_drive_reg    <= mms_pkg::BASE_DRIVE_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                mms_pkg::REG_NEW_WEIGHT:    new_weight_reg    <= cfg_data[W_W-1:0];
                mms_pkg::REG_LEVEL_CEILING: level_ceiling_reg <= cfg_data[MAG_W-1:0];
                mms_pkg::REG_BASE_DRIVE:    base_drive_reg    <= cfg_data[mms_pkg::BASE_W-1:0];
                default:                    ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            bcnt_reg      <= '0;
            level_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_ready && !load_out)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_valid)
                    begin
                        state_reg <= ST_ROOT;
                    end
                end
                ST_ROOT:
                begin
                    if (root_done)
                    begin
                        mag_reg     <= root_mag;
                        wsh_reg     <= w_eff;
                        wcsh_reg    <= w_old;
                        root_sh_reg <= PROD_W'(root_mag);
                        lvl_sh_reg  <= PROD_W'(level_reg);
                        acc_reg     <= '0;
                        bcnt_reg    <= '0;
                        state_reg   <= ST_BLEND;
                    end
                end
                ST_BLEND:
                begin
                    // level*(256-w) + root*w, one weight bit per cycle
                    acc_reg     <= acc_next;
                    wsh_reg     <= wsh_reg >> 1;
                    wcsh_reg    <= wcsh_reg >> 1;
                    root_sh_reg <= root_sh_reg << 1;
                    lvl_sh_reg  <= lvl_sh_reg << 1;
                    bcnt_reg    <= bcnt_reg + 1'b1;
                    if (bcnt_reg == BCNT_W'(W_W - 1))
                    begin
                        state_reg <= ST_FINISH;
                    end
                end
                ST_FINISH:
                begin
                    if (load_out)
                    begin
                        level_reg     <= level_next;
                        magnitude_reg <= mag_reg;
                        smoothed_reg  <= level_next;
                        drive_reg     <= drive_next;
                        out_valid_reg <= 1'b1;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    a_root_done_in_root: assert property (@(posedge clk) disable iff (!rst_n)
        root_done |-> (state_reg == ST_ROOT))
        else $error("root unit finished outside the root wait state");

    a_level_clamped: assert property (@(posedge clk) disable iff (!rst_n)
        load_out |=> (level_reg <= level_ceiling_reg) && (smoothed_reg == level_reg))
        else $error("smoothed level above ceiling or out of step with stored level");

    a_drive_floor: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (drive_reg >= base_drive_reg))
        else $error("drive below base offset");

endmodule

`default_nettype wire
